FILE: rtl/rsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsw_pkg
// Shared sizes, command codes and queue item type for the resampling wheel
// selector.
// ----------------------------------------------------------------------------
package rsw_pkg;

  // particle set and number formats
  localparam int N_PARTICLES = 256;
  localparam int WEIGHT_BITS = 16;
  localparam int RAND_BITS   = 16;
  localparam int OPND_BITS   = 16;
  localparam int OUT_IDX_BITS = 8;

  // derived widths
  localparam int IDX_BITS   = $clog2(N_PARTICLES);
  localparam int CNT_BITS   = $clog2(N_PARTICLES + 1);
  localparam int BETA_BITS  = WEIGHT_BITS + 3;
  localparam int STEP_BITS  = CNT_BITS + 2;
  localparam int PROD_BITS  = WEIGHT_BITS + RAND_BITS;
  localparam int INCR_BITS  = WEIGHT_BITS + 1;
  localparam int SUM_BITS   = BETA_BITS + 1;
  localparam int START_BITS = RAND_BITS + CNT_BITS;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // external command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_DRAW  = 2'd2;

  // classified operation carried in the queue
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_START,
    OP_DRAW
  } op_t;

  typedef struct packed {
    logic                 valid;
    op_t                  op;
    logic [OPND_BITS-1:0] operand;
  } cmd_item_t;

endpackage

FILE: rtl/rsw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsw_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module rsw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rsw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsw_front
// Accepts command transactions, classifies them and queues them for the
// back end. Unknown commands are accepted and dropped.
// ----------------------------------------------------------------------------
module rsw_front import rsw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           cmd,
  input  logic [15:0]          weight,
  input  logic [15:0]          rand_value,
  output logic                 busy,
  output cmd_item_t            head,
  input  logic                 pop
);

  cmd_item_t            slot [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] q_count;
  logic                 accept;
  logic                 push;
  cmd_item_t            item;

  // classify the incoming command
  always_comb begin
    item = '0;
    case (cmd)
      CMD_LOAD: begin
        item.valid   = 1'b1;
        item.op      = OP_LOAD;
        item.operand = weight;
      end
      CMD_START: begin
        item.valid   = 1'b1;
        item.op      = OP_START;
        item.operand = rand_value;
      end
      CMD_DRAW: begin
        item.valid   = 1'b1;
        item.op      = OP_DRAW;
        item.operand = rand_value;
      end
      default: begin
        item = '0;
      end
    endcase
  end

  assign busy   = (q_count == QCNT_BITS'(QUEUE_DEPTH));
  assign accept = start && !busy;
  assign push   = accept && item.valid;

  // queue head toward the back end
  always_comb begin
    head       = slot[rd_ptr];
    head.valid = (q_count != '0);
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= item;
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        q_count <= q_count + 1'b1;
      end else if (pop && !push) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

  // queue never overfills and is never popped while empty
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_BITS'(QUEUE_DEPTH)) else $error("queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (q_count != '0)) else $error("pop from empty queue");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (q_count == $past(q_count) + 1'b1))
    else $error("queue count lost a push");

endmodule

FILE: rtl/rsw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsw_back
// Executes queued commands: loads weights into the store, places the wheel,
// and walks the store for each draw, one weight read per cycle.
// ----------------------------------------------------------------------------
module rsw_back import rsw_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_item_t               head,
  output logic                    pop,
  output logic                    done,
  output logic [OUT_IDX_BITS-1:0] chosen_index,
  output logic                    walk_overrun
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ACCUM = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;

  logic [1:0]             state;
  logic [CNT_BITS-1:0]    count;
  logic [WEIGHT_BITS-1:0] max_weight;
  logic [BETA_BITS-1:0]   beta;
  logic [IDX_BITS-1:0]    idx;
  logic                   phase;
  logic [STEP_BITS-1:0]   steps;
  logic [PROD_BITS-1:0]   prod;

  logic [CNT_BITS-1:0]    eff_count;
  logic [WEIGHT_BITS-1:0] eff_max;
  logic [WEIGHT_BITS-1:0] load_w;
  logic                   load_ok;
  logic                   we;
  logic [START_BITS-1:0]  start_prod;
  logic [IDX_BITS-1:0]    start_idx;
  logic [IDX_BITS-1:0]    idx_ok;
  logic [CNT_BITS-1:0]    idx_inc;
  logic [IDX_BITS-1:0]    idx_next;
  logic [IDX_BITS-1:0]    raddr;
  logic [WEIGHT_BITS-1:0] rdata;
  logic [BETA_BITS-1:0]   w_ext;
  logic [INCR_BITS-1:0]   incr;
  logic [SUM_BITS-1:0]    beta_sum;
  logic [BETA_BITS-1:0]   beta_sat;
  logic [STEP_BITS-1:0]   bound;
  logic                   walk_stop;

  assign pop = (state == S_IDLE) && head.valid;

  // load: a load after draws starts a new set
  assign eff_count = phase ? '0 : count;
  assign eff_max   = phase ? '0 : max_weight;
  assign load_w    = WEIGHT_BITS'(head.operand);
  assign load_ok   = (eff_count < CNT_BITS'(N_PARTICLES));
  assign we        = pop && (head.op == OP_LOAD) && load_ok;

  // start: wheel position from the random fraction
  assign start_prod = START_BITS'(head.operand) * START_BITS'(count);
  assign start_idx  = IDX_BITS'(start_prod >> RAND_BITS);

  // stale index goes back to zero
  assign idx_ok = (CNT_BITS'(idx) >= count) ? '0 : idx;

  // wrapping index step
  assign idx_inc  = CNT_BITS'(idx) + 1'b1;
  assign idx_next = (idx_inc >= count) ? '0 : IDX_BITS'(idx_inc);

  // beta increment 2*max*rand >> 16 with saturation
  assign incr     = prod[PROD_BITS-1:RAND_BITS-1];
  assign beta_sum = SUM_BITS'(beta) + SUM_BITS'(incr);
  assign beta_sat = beta_sum[BETA_BITS] ? '1 : beta_sum[BETA_BITS-1:0];

  assign w_ext = BETA_BITS'(rdata);
  assign bound = STEP_BITS'(count) << 2;
  assign raddr = (state == S_WALK) ? idx_next : idx;

  // walk ends when beta fits the current weight or the step bound is hit
  assign walk_stop = !(beta > w_ext) || (steps >= bound);

  // weight store
  rsw_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (N_PARTICLES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (IDX_BITS'(eff_count)),
    .wdata (load_w),
    .raddr (raddr),
    .rdata (rdata)
  );

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      max_weight <= '0;
      beta       <= '0;
      idx        <= '0;
      phase      <= 1'b0;
      steps      <= '0;
      done       <= 1'b0;
    end else begin
      done <= (state == S_WALK) && walk_stop;
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            case (head.op)
              OP_LOAD: begin
                phase <= 1'b0;
                if (load_ok) begin
                  count      <= eff_count + 1'b1;
                  max_weight <= (load_w > eff_max) ? load_w : eff_max;
                end else begin
                  count      <= eff_count;
                  max_weight <= eff_max;
                end
              end
              OP_START: begin
                phase <= 1'b1;
                beta  <= '0;
                idx   <= start_idx;
              end
              OP_DRAW: begin
                if (count != '0) begin
                  phase <= 1'b1;
                  idx   <= idx_ok;
                  steps <= '0;
                  prod  <= PROD_BITS'(max_weight) * PROD_BITS'(RAND_BITS'(head.operand));
                  state <= S_ACCUM;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_ACCUM: begin
          beta  <= beta_sat;
          state <= S_WALK;
        end
        S_WALK: begin
          if (beta > w_ext) begin
            if (steps >= bound) begin
              walk_overrun <= 1'b1;
              chosen_index <= OUT_IDX_BITS'(idx);
              state        <= S_IDLE;
            end else begin
              beta  <= beta - w_ext;
              idx   <= idx_next;
              steps <= steps + 1'b1;
            end
          end else begin
            walk_overrun <= 1'b0;
            chosen_index <= OUT_IDX_BITS'(idx);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // results come only out of a walk, which stays inside the set and bound
  a_done_after_walk: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_WALK)) else $error("result outside a walk");
  a_walk_in_set: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (CNT_BITS'(idx) < count)) else $error("index outside set");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (steps <= bound)) else $error("walk passed step bound");
  a_store_write_idle: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_IDLE)) else $error("store write during a draw");

endmodule

FILE: rtl/resampling_wheel_selector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resampling_wheel_selector_unit
// Resampling wheel particle index selector: loads weights, places the wheel
// and draws particle indices from a weight store.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   ---------------       ---------------------------------
//  command   start / busy          cmd, weight, rand_value
//  result    done (1-cycle strobe) chosen_index, walk_overrun
//
//  A command is taken when start is high and busy is low; a two-entry queue
//  sits ahead of the executor, and busy rises only when it is full.
//  Load and start are executed from the idle state; a draw goes through an
//  accumulate state and then a walk loop that reads one stored weight per cycle
//  and passes at most 4*count weights before it stops.
//  Result appears on done in the cycle after the walk stops; it cannot be held.
//  Reset (rst, synchronous) empties the queue and clears count, max weight,
//  beta, wheel index and phase; the weight store is not cleared.
//
module resampling_wheel_selector_unit import rsw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [15:0] weight,
  input  logic [15:0] rand_value,
  output logic        done,
  output logic [7:0]  chosen_index,
  output logic        walk_overrun
);

  cmd_item_t head;
  logic      pop;

  // accept and queue commands
  rsw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .weight     (weight),
    .rand_value (rand_value),
    .busy       (busy),
    .head       (head),
    .pop        (pop)
  );

  // execute loads, starts and draws
  rsw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .done         (done),
    .chosen_index (chosen_index),
    .walk_overrun (walk_overrun)
  );

endmodule

FILE: sim/resampling_wheel_selector_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resampling_wheel_selector_unit_test
// Self-checking bench for the resampling wheel selector: a directed table
// covers empty sets, carried-over beta, walk overrun and stale wheel index,
// then random weight sets with start and draw commands are checked against
// a behavioral wheel predictor while the sender idles at varying rates.
// ----------------------------------------------------------------------------
module resampling_wheel_selector_unit_test;
  import rsw_pkg::*;

  // command code with no operation behind it
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [18:0] BETA_CEIL = '1;
  localparam int QUIET_LIMIT = 8000;
  localparam int TAIL_CYCLES = 50;
  localparam int OPENING_ROWS = 25;

  typedef struct packed {
    logic [7:0] idx;
    logic       ovr;
  } pick_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] wt;
    logic [15:0] rnd;
    logic        typed;
    logic [7:0]  idx;
    logic        ovr;
  } row_t;

  localparam pick_t NO_PICK = '0;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  cmd;
  logic [15:0] weight;
  logic [15:0] rand_value;
  logic        done;
  logic [7:0]  chosen_index;
  logic        walk_overrun;

  // wheel predictor state
  logic [15:0] wt_mem [N_PARTICLES];
  logic [8:0]  set_size;
  logic [15:0] peak_weight;
  logic [18:0] beta;
  logic [7:0]  wheel_pos;
  bit          drawing;

  pick_t pending_picks [$];
  int    mismatches;
  int    quiet_cycles;
  int    idle_pct;
  row_t  opening_rows [OPENING_ROWS];

  resampling_wheel_selector_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .weight       (weight),
    .rand_value   (rand_value),
    .done         (done),
    .chosen_index (chosen_index),
    .walk_overrun (walk_overrun)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // turn the wheel for one accepted command
  function automatic void turn_wheel(input logic [1:0] c, input logic [15:0] w,
                                     input logic [15:0] r, output bit emits,
                                     output pick_t pick);
    logic [33:0] prod;
    logic [19:0] sum;
    int unsigned steps;
    emits = 0;
    pick  = '0;
    steps = 0;
    case (c)
      CMD_LOAD: begin
        // first load after draws opens a new set
        if (drawing) begin
          set_size    = '0;
          peak_weight = '0;
          drawing     = 0;
        end
        if (set_size < N_PARTICLES) begin
          wt_mem[set_size[7:0]] = w;
          set_size = set_size + 9'd1;
          if (w > peak_weight) peak_weight = w;
        end
      end
      CMD_START: begin
        drawing = 1;
        beta    = '0;
        prod    = 34'(r) * 34'(set_size);
        wheel_pos = prod[23:16];
        if (9'(wheel_pos) >= set_size) wheel_pos = '0;
      end
      CMD_DRAW: begin
        if (set_size != 0) begin
          drawing = 1;
          if (9'(wheel_pos) >= set_size) wheel_pos = '0;
          prod = (34'(peak_weight) * 34'(r)) << 1;
          sum  = 20'(beta) + 20'(prod >> 16);
          beta = (sum > 20'(BETA_CEIL)) ? BETA_CEIL : sum[18:0];
          // walk while beta is past the current weight, bounded by four laps
          while (beta > 19'(wt_mem[wheel_pos])) begin
            if (steps >= 4 * int'(set_size)) begin
              pick.ovr = 1'b1;
              break;
            end
            beta = beta - 19'(wt_mem[wheel_pos]);
            if (9'(wheel_pos) + 9'd1 >= set_size) wheel_pos = '0;
            else wheel_pos = wheel_pos + 8'd1;
            steps++;
          end
          pick.idx = wheel_pos;
          emits = 1;
        end
      end
      default: ;
    endcase
  endfunction

  // drive one transaction, hold it until taken, then record the prediction
  task automatic issue(input logic [1:0] c, input logic [15:0] w, input logic [15:0] r,
                       input bit typed, input pick_t typed_pick);
    bit    emits;
    pick_t pick;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    cmd        <= c;
    weight     <= w;
    rand_value <= r;
    do @(posedge clk); while (busy);
    turn_wheel(c, w, r, emits, pick);
    if (emits) pending_picks.push_back(typed ? typed_pick : pick);
  endtask

  // stop sending until every outstanding draw has reported
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_picks.size() != 0) @(posedge clk);
  endtask

  // random weight sets, each mostly loaded, placed and drawn from
  task automatic play_sets(input int quota);
    int sent;
    int set_len;
    int style;
    int draws;
    logic [15:0] w;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 82) begin
        set_len = ($urandom_range(19) == 0) ? $urandom_range(40, 96) : $urandom_range(1, 10);
        style   = $urandom_range(3);
        for (int i = 0; i < set_len; i++) begin
          case (style)
            0: w = 16'($urandom);
            1: w = 16'($urandom_range(255));
            2: w = ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0000;
            default: begin
              case ($urandom_range(3))
                0: w = 16'h0000;
                1: w = 16'h0001;
                2: w = 16'h8000;
                default: w = 16'hFFFF;
              endcase
            end
          endcase
          issue(CMD_LOAD, w, 16'($urandom), 0, NO_PICK);
        end
        // sometimes draw straight on from the carried-over wheel
        if ($urandom_range(99) < 85) begin
          issue(CMD_START, 16'($urandom), 16'($urandom), 0, NO_PICK);
        end
        draws = $urandom_range(1, 8);
        for (int i = 0; i < draws; i++) begin
          if ($urandom_range(15) == 0) begin
            issue(CMD_UNUSED, 16'($urandom), 16'($urandom), 0, NO_PICK);
          end
          issue(CMD_DRAW, 16'($urandom), 16'($urandom), 0, NO_PICK);
        end
        sent += set_len + 1 + draws;
      end else begin
        // loose commands in any order
        repeat ($urandom_range(1, 4)) begin
          issue(2'($urandom_range(3)), 16'($urandom), 16'($urandom), 0, NO_PICK);
          sent++;
        end
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_picks
    pick_t want;
    if (!rst && done) begin
      if (pending_picks.size() == 0) begin
        $display("%0t ns: result with nothing expected, index %0d overrun %0b",
                 $time, chosen_index, walk_overrun);
        mismatches++;
      end else begin
        want = pending_picks.pop_front();
        if (chosen_index !== want.idx) begin
          $display("%0t ns: chosen_index expected %0d got %0d", $time, want.idx, chosen_index);
          mismatches++;
        end
        if (walk_overrun !== want.ovr) begin
          $display("%0t ns: walk_overrun expected %0b got %0b", $time, want.ovr, walk_overrun);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    cmd         = CMD_LOAD;
    weight      = '0;
    rand_value  = '0;
    set_size    = '0;
    peak_weight = '0;
    beta        = '0;
    wheel_pos   = '0;
    drawing     = 0;
    mismatches  = 0;
    idle_pct    = 0;

    // op, weight, rand, typed, index, overrun
    opening_rows = '{
      '{CMD_DRAW,   16'hFFFF, 16'h1234, 1'b0, 8'd0, 1'b0},  // empty set, no result
      '{CMD_UNUSED, 16'hFFFF, 16'hFFFF, 1'b0, 8'd0, 1'b0},
      '{CMD_START,  16'h0000, 16'hFFFF, 1'b0, 8'd0, 1'b0},  // start on empty set
      '{CMD_DRAW,   16'h0000, 16'h0000, 1'b0, 8'd0, 1'b0},
      '{CMD_LOAD,   16'hFFFF, 16'h0000, 1'b0, 8'd0, 1'b0},  // new set after draws
      '{CMD_START,  16'h5A5A, 16'hFFFF, 1'b0, 8'd0, 1'b0},
      '{CMD_DRAW,   16'hA5A5, 16'hFFFF, 1'b1, 8'd0, 1'b0},  // largest increment
      '{CMD_LOAD,   16'h0001, 16'hFFFF, 1'b0, 8'd0, 1'b0},
      '{CMD_DRAW,   16'h0000, 16'h0000, 1'b1, 8'd0, 1'b1},  // no start, beta carried
      '{CMD_LOAD,   16'h0000, 16'h0000, 1'b0, 8'd0, 1'b0},
      '{CMD_LOAD,   16'h0000, 16'h0000, 1'b0, 8'd0, 1'b0},
      '{CMD_DRAW,   16'hFFFF, 16'hFFFF, 1'b1, 8'd0, 1'b1},  // all-zero set
      '{CMD_START,  16'h0000, 16'h0000, 1'b0, 8'd0, 1'b0},
      '{CMD_DRAW,   16'h0000, 16'h0000, 1'b1, 8'd0, 1'b0},
      '{CMD_LOAD,   16'h0000, 16'h0000, 1'b0, 8'd0, 1'b0},
      '{CMD_LOAD,   16'h8000, 16'h0000, 1'b0, 8'd0, 1'b0},
      '{CMD_LOAD,   16'h0001, 16'h0000, 1'b0, 8'd0, 1'b0},
      '{CMD_LOAD,   16'h7FFF, 16'h0000, 1'b0, 8'd0, 1'b0},
      '{CMD_START,  16'h0000, 16'hFFFF, 1'b0, 8'd0, 1'b0},  // wheel at last entry
      '{CMD_DRAW,   16'h0000, 16'h0000, 1'b1, 8'd3, 1'b0},
      '{CMD_LOAD,   16'h4000, 16'h0000, 1'b0, 8'd0, 1'b0},
      '{CMD_LOAD,   16'h4000, 16'h0000, 1'b0, 8'd0, 1'b0},
      '{CMD_DRAW,   16'h0000, 16'h8000, 1'b1, 8'd0, 1'b0},  // stale index wraps to zero
      '{CMD_DRAW,   16'h0000, 16'h8001, 1'b1, 8'd1, 1'b0},
      '{CMD_UNUSED, 16'h0000, 16'h0000, 1'b0, 8'd0, 1'b0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < OPENING_ROWS; i++) begin
      issue(opening_rows[i].op, opening_rows[i].wt, opening_rows[i].rnd,
            opening_rows[i].typed, '{opening_rows[i].idx, opening_rows[i].ovr});
    end
    settle();

    // light sender gaps
    idle_pct = 6;
    play_sets(85);
    settle();

    // heavy sender gaps
    idle_pct = 58;
    play_sets(85);
    settle();

    // back to back, with one full store and loads past its end
    idle_pct = 0;
    for (int i = 0; i < N_PARTICLES + 3; i++) begin
      issue(CMD_LOAD, 16'($urandom), 16'($urandom), 0, NO_PICK);
    end
    issue(CMD_START, 16'($urandom), 16'($urandom), 0, NO_PICK);
    repeat (4) issue(CMD_DRAW, 16'($urandom), 16'($urandom), 0, NO_PICK);
    play_sets(85);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_picks.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
